// File: sv/dsf_pkg.sv
// dsf_pkg: codes, constants and controller/datapath handshake structs of the
// djb2 shred fingerprint block. No dependencies.
package dsf_pkg;

  // default fingerprint vector size in bits (a power of two, 64 to 2^15)
  localparam int unsigned VECTOR_BITS_DEFAULT = 32768;

  // djb2 seed and register reset value
  localparam logic [31:0] HASH_SEED       = 32'd5381;
  localparam logic [6:0]  SHRED_LEN_RESET = 7'd16;

  // input command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SHRED = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_SHRED = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic in_ready;    // take an input transaction this cycle if valid
    logic sweep_wr;    // write zero at the sweep counter
    logic rmw_wr;      // write back the word with the shred bit set
    logic load_read;   // present read data as a result
    logic load_clear;  // present clear done as a result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] command;
    logic       shred_done;  // the offered byte completes a shred
    logic       sweep_last;  // sweep counter on the final word
    logic       out_free;    // output register empty or being taken
  } ctrl_status_t;

endpackage

// File: sv/dsf_interfaces.sv
// dsf interfaces: input item, result and configuration write channels.
// Depends on nothing; valid/ready handshake on each.
interface dsf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [8:0] word_index;

  modport source (output valid, command, data_byte, word_index, input ready);
  modport sink   (input valid, command, data_byte, word_index, output ready);
endinterface

interface dsf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] hash_value;
  logic [14:0] bit_position;
  logic [63:0] word_data;

  modport source (output valid, result_kind, hash_value, bit_position, word_data,
                  input ready);
  modport sink   (input valid, result_kind, hash_value, bit_position, word_data,
                  output ready);
endinterface

interface dsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] shred_length;

  modport source (output valid, shred_length, input ready);
  modport sink   (input valid, shred_length, output ready);
endinterface

// File: sv/dsf_datapath.sv
// dsf_datapath: djb2 hash accumulator, fingerprint store memory, sweep counter,
// output register and configuration register. Depends on dsf_pkg, dsf interfaces.
module dsf_datapath #(
  parameter int unsigned VECTOR_BITS = dsf_pkg::VECTOR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  dsf_item_if.sink             items,
  dsf_result_if.source         results,
  dsf_cfg_if.sink              cfg,
  input  dsf_pkg::ctrl_cmd_t   cmd,
  output dsf_pkg::ctrl_status_t status
);

  localparam int unsigned STORE_WORDS = VECTOR_BITS / 64;
  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [31:0] POS_MASK   = 32'(VECTOR_BITS - 1);
  localparam logic [31:0] WORDS_32   = 32'(STORE_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

  logic [63:0]   store_mem [STORE_WORDS];
  logic [63:0]   rdata;
  logic [AW-1:0] addr;
  logic [5:0]    bit_sel;
  logic          rd_in_range;
  logic [AW-1:0] sweep_cnt;

  logic [31:0]   running_hash;
  logic [6:0]    byte_count;
  logic [6:0]    shred_length;

  logic [31:0]   hash_next;
  logic [6:0]    count_next;
  logic [6:0]    len_eff;
  logic [31:0]   pos32;
  logic          accept;
  logic          take_byte;
  logic          shred_done;

  logic          out_valid;
  logic [1:0]    out_kind;
  logic [31:0]   out_hash;
  logic [14:0]   out_pos;
  logic [63:0]   out_word;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  // djb2 step and shred end detection
  assign hash_next  = (running_hash << 5) + running_hash + {24'd0, items.data_byte};
  assign count_next = byte_count + 7'd1;
  assign len_eff    = (shred_length == 7'd0) ? 7'd1 : shred_length;
  assign shred_done = (count_next >= len_eff);
  assign pos32      = hash_next & POS_MASK;

  assign accept    = items.valid && cmd.in_ready;
  assign take_byte = accept && (items.command == dsf_pkg::CMD_SHRED);

  // handshakes
  assign items.ready = cmd.in_ready;
  assign cfg.ready   = 1'b1;

  assign status.in_valid   = items.valid;
  assign status.command    = items.command;
  assign status.shred_done = shred_done;
  assign status.sweep_last = (sweep_cnt == LAST_WORD);
  assign status.out_free   = !out_valid || results.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      shred_length <= dsf_pkg::SHRED_LEN_RESET;
    end else if (cfg.valid) begin
      shred_length <= cfg.shred_length;
    end
  end

  // running hash and byte count of the current shred
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= dsf_pkg::HASH_SEED;
      byte_count   <= 7'd0;
    end else if (take_byte) begin
      if (shred_done) begin
        running_hash <= dsf_pkg::HASH_SEED;
        byte_count   <= 7'd0;
      end else begin
        running_hash <= hash_next;
        byte_count   <= count_next;
      end
    end
  end

  // store address and bit select, captured at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      if (items.command == dsf_pkg::CMD_SHRED) begin
        addr <= AW'(pos32 >> 6);
      end else begin
        addr <= AW'(items.word_index);
      end
      bit_sel     <= pos32[5:0];
      rd_in_range <= ({23'd0, items.word_index} < WORDS_32);
    end
  end

  // sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + AW'(1);
    end
  end

  // store write port: zero sweep or read-modify-write
  assign mem_we    = cmd.sweep_wr || cmd.rmw_wr;
  assign mem_waddr = cmd.sweep_wr ? sweep_cnt : addr;
  assign mem_wdata = cmd.sweep_wr ? 64'd0 : (rdata | (64'd1 << bit_sel));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    rdata <= store_mem[addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rmw_wr || cmd.load_read || cmd.load_clear) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte && shred_done) begin
      out_kind <= dsf_pkg::KIND_SHRED;
      out_hash <= hash_next;
      out_pos  <= pos32[14:0];
      out_word <= 64'd0;
    end else if (cmd.load_read) begin
      out_kind <= dsf_pkg::KIND_READ;
      out_hash <= 32'd0;
      out_pos  <= 15'd0;
      out_word <= rd_in_range ? rdata : 64'd0;
    end else if (cmd.load_clear) begin
      out_kind <= dsf_pkg::KIND_CLEAR;
      out_hash <= 32'd0;
      out_pos  <= 15'd0;
      out_word <= 64'd0;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_kind  = out_kind;
  assign results.hash_value   = out_hash;
  assign results.bit_position = out_pos;
  assign results.word_data    = out_word;

endmodule

// File: sv/dsf_controller.sv
// dsf_controller: sequencer for store sweeps, bit-set read-modify-write and
// word reads. Depends on dsf_pkg.
module dsf_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  dsf_pkg::ctrl_status_t status,
  output dsf_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_RD_WAIT,
    S_RD_OUT
  } state_t;

  state_t state;
  logic   report;  // sweep was asked for by a clear command
  logic   accept;

  // command decode from state
  always_comb begin
    cmd            = '0;
    cmd.in_ready   = (state == S_IDLE) && status.out_free;
    cmd.sweep_wr   = (state == S_SWEEP);
    cmd.rmw_wr     = (state == S_RMW_WR);
    cmd.load_read  = (state == S_RD_OUT);
    cmd.load_clear = (state == S_SWEEP) && status.sweep_last && report;
  end

  assign accept = cmd.in_ready && status.in_valid;

  // state register; reset starts the clearing pass with no report
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      report <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (status.sweep_last) begin
            state  <= S_IDLE;
            report <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (status.command)
              dsf_pkg::CMD_CLEAR: begin
                state  <= S_SWEEP;
                report <= 1'b1;
              end
              dsf_pkg::CMD_SHRED: begin
                if (status.shred_done) begin
                  state <= S_RMW_RD;
                end
              end
              dsf_pkg::CMD_READ: begin
                state <= S_RD_WAIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RMW_RD:  state <= S_RMW_WR;
        S_RMW_WR:  state <= S_IDLE;
        S_RD_WAIT: state <= S_RD_OUT;
        S_RD_OUT:  state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/djb2_shred_fingerprint.sv
// djb2 shred fingerprint: shred bytes that do not end a shred go at one per cycle
// while the output register is free, with no result. A shred's last byte gives its
// result via S_RMW_RD, S_RMW_WR (store read-modify-write), no item taken meanwhile;
// a word read gives its result via S_RD_WAIT, S_RD_OUT. A clear sweeps
// VECTOR_BITS/64 words, one a cycle, then reports. After reset the same sweep runs
// with no result and items.ready low; configuration writes are taken always.
module djb2_shred_fingerprint #(
  parameter int unsigned VECTOR_BITS = dsf_pkg::VECTOR_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dsf_item_if.sink     items,
  dsf_result_if.source results,
  dsf_cfg_if.sink      cfg
);

  dsf_pkg::ctrl_cmd_t    cmd;
  dsf_pkg::ctrl_status_t status;

  // sequencer
  dsf_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // hash, store and output register
  dsf_datapath #(
    .VECTOR_BITS (VECTOR_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// File: tb/sv/tb_djb2_shred_fingerprint.sv
// tb_djb2_shred_fingerprint: self-checking testbench for the djb2 shred fingerprint block.
// Depends on dsf_pkg and the dsf interfaces; predicts each result when its item
// transaction is accepted and checks results in order as they leave the block.
module tb_djb2_shred_fingerprint;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FP_BITS       = dsf_pkg::VECTOR_BITS_DEFAULT;
  localparam int unsigned FP_WORDS      = FP_BITS / 64;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned NUM_PHASES    = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] hash;
    logic [14:0] pos;
    logic [63:0] word;
  } fp_result_t;

  logic clk = 1'b0;
  logic rst;

  dsf_item_if   item_ch ();
  dsf_result_if result_ch ();
  dsf_cfg_if    cfg_ch ();

  djb2_shred_fingerprint #(.VECTOR_BITS(FP_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // predicted state of the block
  logic [63:0] fp_words [FP_WORDS];
  logic [31:0] fp_hash;
  logic [6:0]  fp_count;
  logic [6:0]  fp_len;
  logic [14:0] fp_last_pos = '0;
  fp_result_t  fp_expected [$];
  fp_result_t  oldest;

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;  // no idling on either side

  always #6 clk = ~clk;

  // work out the result of one accepted item and advance the predicted state
  function automatic void predict_fingerprint(input logic [1:0] cmd, input logic [7:0] data,
                                              input logic [8:0] idx);
    fp_result_t  res;
    logic [6:0]  len;
    int unsigned bit_idx;
    res = '0;
    case (cmd)
      dsf_pkg::CMD_CLEAR: begin
        foreach (fp_words[w]) fp_words[w] = '0;
        res.kind = dsf_pkg::KIND_CLEAR;
        fp_expected.push_back(res);
      end
      dsf_pkg::CMD_READ: begin
        res.kind = dsf_pkg::KIND_READ;
        res.word = (idx < FP_WORDS) ? fp_words[idx] : 64'd0;
        fp_expected.push_back(res);
      end
      dsf_pkg::CMD_SHRED: begin
        // a length of zero behaves as one
        len      = (fp_len == 7'd0) ? 7'd1 : fp_len;
        fp_hash  = fp_hash * 32'd33 + {24'd0, data};
        fp_count = fp_count + 7'd1;
        if (fp_count >= len) begin
          bit_idx = fp_hash % FP_BITS;
          if ((bit_idx / 64) < FP_WORDS) fp_words[bit_idx / 64][bit_idx % 64] = 1'b1;
          res.kind    = dsf_pkg::KIND_SHRED;
          res.hash    = fp_hash;
          res.pos     = bit_idx[14:0];
          fp_last_pos = res.pos;
          fp_expected.push_back(res);
          fp_hash     = dsf_pkg::HASH_SEED;
          fp_count    = 7'd0;
        end
      end
      default: ;  // unused command leaves everything alone
    endcase
  endfunction

  // offer one item transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [8:0] idx);
    while (!steady && $urandom_range(99) < 12) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.command    <= cmd;
    item_ch.data_byte  <= data;
    item_ch.word_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
    predict_fingerprint(cmd, data, idx);
  endtask

  // hold the sender off until every outstanding result is in and the block is quiet
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (fp_expected.size() != 0) @(posedge clk);
    // a partial byte gives no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shred_length(input logic [6:0] len);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.shred_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fp_len = len;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  data;
    logic [8:0]  idx;
    pick = $urandom_range(999);
    data = 8'($urandom_range(255));
    idx  = 9'($urandom_range(511));
    if (pick < 8) send_item(dsf_pkg::CMD_CLEAR, data, idx);
    else if (pick < 18) send_item(CMD_UNUSED, data, idx);
    else if (pick < 150)
      send_item(dsf_pkg::CMD_READ, data, pick[0] ? fp_last_pos[14:6] : idx);
    else send_item(dsf_pkg::CMD_SHRED, data, idx);
  endtask

  // empty store after reset, both ends of the word range, unused command
  task automatic test_empty_reads();
    send_item(dsf_pkg::CMD_READ, 8'h00, 9'd0);
    send_item(dsf_pkg::CMD_READ, 8'hFF, 9'h1FF);
    send_item(CMD_UNUSED, 8'hA5, 9'h0AA);
    send_item(dsf_pkg::CMD_READ, 8'h5A, 9'h155);
  endtask

  // one shred at the reset length, read back its bit, clear and read again
  task automatic test_default_shred();
    for (int i = 0; i < 16; i++)
      send_item(dsf_pkg::CMD_SHRED, i[0] ? 8'hFF : 8'h00, 9'h1FF);
    send_item(dsf_pkg::CMD_READ, 8'h00, fp_last_pos[14:6]);
    send_item(dsf_pkg::CMD_CLEAR, 8'h00, 9'd0);
    send_item(dsf_pkg::CMD_READ, 8'h00, fp_last_pos[14:6]);
  endtask

  // zero length, longest length, length lowered mid-shred, clear during a shred
  task automatic test_shred_length();
    drain_results();
    write_shred_length(7'd0);
    send_item(dsf_pkg::CMD_SHRED, 8'hFF, 9'd0);
    send_item(dsf_pkg::CMD_SHRED, 8'h00, 9'd0);
    drain_results();
    write_shred_length(7'd127);
    repeat (3) send_item(dsf_pkg::CMD_SHRED, 8'h80, 9'd0);
    drain_results();
    // count already past the new length, so the next byte ends the shred
    write_shred_length(7'd2);
    send_item(dsf_pkg::CMD_SHRED, 8'h01, 9'd0);
    send_item(dsf_pkg::CMD_READ, 8'h00, fp_last_pos[14:6]);
    drain_results();
    // clear keeps the partial shred
    write_shred_length(7'd3);
    send_item(dsf_pkg::CMD_SHRED, 8'h7F, 9'd0);
    send_item(dsf_pkg::CMD_CLEAR, 8'h00, 9'd0);
    send_item(dsf_pkg::CMD_SHRED, 8'h00, 9'd0);
    send_item(dsf_pkg::CMD_SHRED, 8'hFF, 9'd0);
    send_item(dsf_pkg::CMD_READ, 8'h00, fp_last_pos[14:6]);
  endtask

  // random traffic over several shred lengths, extremes included
  task automatic test_random_phases();
    logic [6:0]  lengths [NUM_PHASES];
    int unsigned per_phase;
    lengths    = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd3, 7'd16, 7'd2, 7'd5};
    lengths[6] = 7'($urandom_range(2, 10));
    per_phase  = RANDOM_ITEMS / NUM_PHASES;
    foreach (lengths[p]) begin
      drain_results();
      write_shred_length(lengths[p]);
      steady = (p == 4);
      for (int i = 0; i < per_phase; i++) begin
        if (p == 2 && i == per_phase / 2) drain_results();
        send_random_item();
      end
    end
    steady = 1'b0;
  endtask

  // receiver stalls at random
  always @(posedge clk) result_ch.ready <= steady || ($urandom_range(99) >= 12);

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (fp_expected.size() == 0) begin
        $error("result_kind: expected none, actual %0d", result_ch.result_kind);
        error_count++;
      end else begin
        oldest = fp_expected.pop_front();
        compare_field("result_kind", 64'(oldest.kind), 64'(result_ch.result_kind));
        compare_field("hash_value", 64'(oldest.hash), 64'(result_ch.hash_value));
        compare_field("bit_position", 64'(oldest.pos), 64'(result_ch.bit_position));
        compare_field("word_data", oldest.word, result_ch.word_data);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // reset, then the tests in turn
  initial begin
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.command     <= dsf_pkg::CMD_CLEAR;
    item_ch.data_byte   <= 8'd0;
    item_ch.word_index  <= 9'd0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.shred_length <= dsf_pkg::SHRED_LEN_RESET;
    foreach (fp_words[w]) fp_words[w] = '0;
    fp_hash  = dsf_pkg::HASH_SEED;
    fp_count = 7'd0;
    fp_len   = dsf_pkg::SHRED_LEN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_reads();
    test_default_shred();
    test_shred_length();
    test_random_phases();
    drain_results();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
